[src/mjfd_pkg.sv]
`timescale 1ns / 1ps
// Shared codes and field widths for the multi-joint FIR differentiator.
// Has no dependencies; the top level refers to it by scoped names.
package mjfd_pkg;

	localparam int POS_W  = 32;
	localparam int JIDX_W = 4;
	localparam int TAPI_W = 3;
	localparam int TCFG_W = 4;
	localparam int JCNT_W = 5;
	localparam int NUM_FILT = 3;

	localparam logic [1:0] MODE_SYNC   = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_COEF   = 2'd2;

	localparam logic [1:0] FILT_POS  = 2'd0;
	localparam logic [1:0] FILT_VEL  = 2'd1;
	localparam logic [1:0] FILT_ACC  = 2'd2;
	localparam logic [1:0] FILT_NONE = 2'd3;

	localparam logic [2:0] REG_JOINT_COUNT = 3'd0;
	localparam logic [2:0] REG_POS_EN      = 3'd1;
	localparam logic [2:0] REG_VEL_EN      = 3'd2;
	localparam logic [2:0] REG_ACC_EN      = 3'd3;
	localparam logic [2:0] REG_POS_TAPS    = 3'd4;
	localparam logic [2:0] REG_VEL_TAPS    = 3'd5;
	localparam logic [2:0] REG_ACC_TAPS    = 3'd6;

	typedef logic [TCFG_W-1:0] tap_cfg_t;

endpackage

[src/multi_joint_fir_differentiator.sv]
`timescale 1ns / 1ps
// Top level of the multi-joint FIR differentiator: history memory, coefficient
// memory, one shared multiply-accumulate unit and its sequencer. Uses mjfd_pkg.

// Each joint sample gives one result built from three FIR filters that share one
// 32x32 multiplier and one accumulator, one tap per cycle. A sample that primes the
// history first writes its position into every history slot of its joint. The sequencer
// then skips a disabled filter, takes an enabled filter with zero taps straight to its
// result, and otherwise issues its taps, drains the single multiplier and its two
// pipeline stages and stores the rounded result. A result that waits for m_axis_tready
// holds the sequencer in its last state. Sync ticks and coefficient loads are handled in
// the idle state. Configuration writes are accepted only while the block is idle or
// sweeping the history, with no result waiting. After reset, and after any write that
// changes joint_count, the history memory is swept to zero while no item is accepted.
module multi_joint_fir_differentiator #(
	parameter int MAX_JOINTS = 16,
	parameter int MAX_TAPS   = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// joint_index, position_in, velocity_in, filter_select, tap_index, coefficient
	input  logic [111:0] s_axis_tdata,
	// mode
	input  logic [1:0]   s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// joint_out, position_out, velocity_out, acceleration_out
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [4:0]   cfg_data
);

	localparam int SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int JNT_W  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int TCNT_W = $clog2(MAX_TAPS + 1);
	localparam int ACC_W  = 65 + $clog2(MAX_TAPS);
	localparam int PW     = mjfd_pkg::POS_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PRIME = 3'd2;
	localparam logic [2:0] ST_SEL   = 3'd3;
	localparam logic [2:0] ST_ISSUE = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

	// Input fields.
	logic [1:0]               in_mode;
	logic [3:0]               in_joint;
	logic [PW-1:0]            in_pos;
	logic [PW-1:0]            in_vel;
	logic [1:0]               in_sel;
	logic [2:0]               in_tap;
	logic [PW-1:0]            in_coef;
	logic                     in_acc;
	logic                     cfg_acc;

	assign in_mode  = s_axis_tuser;
	assign in_joint = s_axis_tdata[3:0];
	assign in_pos   = s_axis_tdata[35:4];
	assign in_vel   = s_axis_tdata[67:36];
	assign in_sel   = s_axis_tdata[69:68];
	assign in_tap   = s_axis_tdata[72:70];
	assign in_coef  = s_axis_tdata[104:73];

	// Configuration.
	logic [mjfd_pkg::JCNT_W-1:0] jcount_q;
	logic                        pos_en_q;
	logic                        vel_en_q;
	logic                        acc_en_q;
	mjfd_pkg::tap_cfg_t          taps_q [mjfd_pkg::NUM_FILT];

	// Control state.
	logic [2:0]          state_q;
	logic [SLOT_W-1:0]   newest_q;
	logic                new_cycle_q;
	logic                primed_q;
	logic [SLOT_W-1:0]   clr_slot_q;
	logic [JNT_W-1:0]    clr_jnt_q;
	logic [1:0]          filt_q;
	logic [TCNT_W-1:0]   k_q;
	logic                v_s1;
	logic                v_s2;
	logic                m_valid_q;

	// Item payload.
	logic [JNT_W-1:0]    joint_q;
	logic [3:0]          joint_id_q;
	logic                last_q;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       vel_q;
	logic [PW-1:0]       res_q [mjfd_pkg::NUM_FILT];
	logic signed [ACC_W-1:0] acc_q;

	logic [3:0]          out_joint_q;
	logic [PW-1:0]       out_pos_q;
	logic [PW-1:0]       out_vel_q;
	logic [PW-1:0]       out_accel_q;
	logic                out_last_q;

	// Memories.
	logic [PW-1:0]       hist_mem [MAX_TAPS][MAX_JOINTS];
	logic [PW-1:0]       coef_mem [mjfd_pkg::NUM_FILT][MAX_TAPS];
	logic                coef_vld_q [mjfd_pkg::NUM_FILT][MAX_TAPS];
	logic [PW-1:0]       hist_rd_s1;
	logic [PW-1:0]       coef_rd_s1;
	logic                coef_vld_s1;
	logic signed [63:0]  prod_s2;

	// Derived values.
	logic [JNT_W+3:0]    joint_ext;
	logic [JNT_W-1:0]    joint_w;
	logic [SLOT_W+2:0]   tap_ext;
	logic [SLOT_W-1:0]   tap_w;
	logic                joint_ok;
	logic                coef_ok;
	logic [SLOT_W-1:0]   newest_inc;
	logic [SLOT_W:0]     rd_sum;
	logic [SLOT_W-1:0]   rd_slot;
	logic [SLOT_W-1:0]   k_slot;
	logic [TCNT_W-1:0]   eff_taps [mjfd_pkg::NUM_FILT];
	logic [TCNT_W-1:0]   taps_sel;
	logic                en_sel;
	logic signed [ACC_W-1:0] rnd_w;
	logic signed [ACC_W-1:0] shr_w;
	logic [PW-1:0]       sat_w;
	logic                hist_we;
	logic [SLOT_W-1:0]   hist_ws;
	logic [JNT_W-1:0]    hist_wj;
	logic [PW-1:0]       hist_wd;
	logic                coef_we;
	logic                jcount_chg;

	assign joint_ext  = {{JNT_W{1'b0}}, in_joint};
	assign joint_w    = joint_ext[JNT_W-1:0];
	assign tap_ext    = {{SLOT_W{1'b0}}, in_tap};
	assign tap_w      = tap_ext[SLOT_W-1:0];
	assign joint_ok   = ({1'b0, in_joint} < jcount_q) && (32'(in_joint) < MAX_JOINTS);
	assign coef_ok    = (in_sel != mjfd_pkg::FILT_NONE) && (32'(in_tap) < MAX_TAPS);
	assign newest_inc = (32'(newest_q) == MAX_TAPS - 1) ? '0 : newest_q + 1'b1;
	assign k_slot     = k_q[SLOT_W-1:0];
	assign rd_sum     = ({1'b0, newest_q} >= {1'b0, k_slot}) ?
		({1'b0, newest_q} - {1'b0, k_slot}) :
		({1'b0, newest_q} + (SLOT_W+1)'(MAX_TAPS) - {1'b0, k_slot});
	assign rd_slot    = rd_sum[SLOT_W-1:0];

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign cfg_ready = ((state_q == ST_CLEAR) || (state_q == ST_IDLE)) && !m_valid_q;
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign jcount_chg = cfg_acc && (cfg_index == mjfd_pkg::REG_JOINT_COUNT) &&
		(cfg_data != jcount_q);

	always_comb begin
		for (int f = 0; f < mjfd_pkg::NUM_FILT; f++) begin
			eff_taps[f] = (32'(taps_q[f]) > MAX_TAPS) ? TCNT_W'(MAX_TAPS) : TCNT_W'(taps_q[f]);
		end
	end

	always_comb begin
		case (filt_q)
			mjfd_pkg::FILT_POS: begin
				en_sel   = pos_en_q;
				taps_sel = eff_taps[0];
			end
			mjfd_pkg::FILT_VEL: begin
				en_sel   = vel_en_q;
				taps_sel = eff_taps[1];
			end
			mjfd_pkg::FILT_ACC: begin
				en_sel   = acc_en_q;
				taps_sel = eff_taps[2];
			end
			default: begin
				en_sel   = 1'b0;
				taps_sel = '0;
			end
		endcase
	end

	// Round to nearest with ties upward, then saturate to 32 bits.
	assign rnd_w = acc_q + RND_HALF;
	assign shr_w = rnd_w >>> 16;
	always_comb begin
		if ((&shr_w[ACC_W-1:PW-1]) || !(|shr_w[ACC_W-1:PW-1])) begin
			sat_w = shr_w[PW-1:0];
		end else if (shr_w[ACC_W-1]) begin
			sat_w = {1'b1, {(PW-1){1'b0}}};
		end else begin
			sat_w = {1'b0, {(PW-1){1'b1}}};
		end
	end

	// History write port.
	always_comb begin
		hist_we = 1'b0;
		hist_ws = clr_slot_q;
		hist_wj = clr_jnt_q;
		hist_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
			end
			ST_PRIME: begin
				hist_we = 1'b1;
				hist_ws = k_slot;
				hist_wj = joint_q;
				hist_wd = pos_q;
			end
			ST_IDLE: begin
				if (in_acc && (in_mode == mjfd_pkg::MODE_SAMPLE) && joint_ok && primed_q) begin
					hist_we = 1'b1;
					hist_ws = new_cycle_q ? newest_inc : newest_q;
					hist_wj = joint_w;
					hist_wd = in_pos;
				end
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
	end

	assign coef_we = in_acc && (in_mode == mjfd_pkg::MODE_COEF) && coef_ok;

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_ws][hist_wj] <= hist_wd;
		end
		if (coef_we) begin
			coef_mem[in_sel][tap_w] <= in_coef;
		end
		hist_rd_s1 <= hist_mem[rd_slot][joint_q];
		coef_rd_s1 <= coef_mem[filt_q][k_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < mjfd_pkg::NUM_FILT; f++) begin
				for (int t = 0; t < MAX_TAPS; t++) begin
					coef_vld_q[f][t] <= 1'b0;
				end
			end
		end else if (coef_we) begin
			coef_vld_q[in_sel][tap_w] <= 1'b1;
		end
	end

	// Shared multiply-accumulate datapath.
	always_ff @(posedge clk) begin
		coef_vld_s1 <= coef_vld_q[filt_q][k_slot];
		prod_s2 <= $signed(hist_rd_s1) * $signed(coef_vld_s1 ? coef_rd_s1 : {PW{1'b0}});
		if (state_q == ST_FIN) begin
			res_q[filt_q] <= sat_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= (state_q == ST_ISSUE);
			v_s2 <= v_s1;
			if (state_q == ST_FIN) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jcount_q <= mjfd_pkg::JCNT_W'(1);
			pos_en_q <= 1'b0;
			vel_en_q <= 1'b0;
			acc_en_q <= 1'b0;
			for (int f = 0; f < mjfd_pkg::NUM_FILT; f++) begin
				taps_q[f] <= '0;
			end
		end else if (cfg_acc) begin
			case (cfg_index)
				mjfd_pkg::REG_JOINT_COUNT: jcount_q <= cfg_data;
				mjfd_pkg::REG_POS_EN:      pos_en_q <= cfg_data[0];
				mjfd_pkg::REG_VEL_EN:      vel_en_q <= cfg_data[0];
				mjfd_pkg::REG_ACC_EN:      acc_en_q <= cfg_data[0];
				mjfd_pkg::REG_POS_TAPS:    taps_q[0] <= cfg_data[3:0];
				mjfd_pkg::REG_VEL_TAPS:    taps_q[1] <= cfg_data[3:0];
				mjfd_pkg::REG_ACC_TAPS:    taps_q[2] <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			newest_q    <= '0;
			new_cycle_q <= 1'b1;
			primed_q    <= 1'b0;
			clr_slot_q  <= '0;
			clr_jnt_q   <= '0;
			filt_q      <= mjfd_pkg::FILT_POS;
			k_q         <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (jcount_chg) begin
				state_q     <= ST_CLEAR;
				newest_q    <= '0;
				new_cycle_q <= 1'b1;
				primed_q    <= 1'b0;
				clr_slot_q  <= '0;
				clr_jnt_q   <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						if (32'(clr_jnt_q) == MAX_JOINTS - 1) begin
							clr_jnt_q <= '0;
							if (32'(clr_slot_q) == MAX_TAPS - 1) begin
								clr_slot_q <= '0;
								state_q    <= ST_IDLE;
							end else begin
								clr_slot_q <= clr_slot_q + 1'b1;
							end
						end else begin
							clr_jnt_q <= clr_jnt_q + 1'b1;
						end
					end
					ST_IDLE: begin
						if (in_acc) begin
							case (in_mode)
								mjfd_pkg::MODE_SYNC: begin
									new_cycle_q <= 1'b1;
								end
								mjfd_pkg::MODE_SAMPLE: begin
									if (joint_ok) begin
										filt_q <= mjfd_pkg::FILT_POS;
										k_q    <= '0;
										new_cycle_q <= 1'b0;
										if (!primed_q) begin
											state_q <= ST_PRIME;
											if (s_axis_tlast) begin
												primed_q <= 1'b1;
											end
										end else begin
											state_q <= ST_SEL;
											if (new_cycle_q) begin
												newest_q <= newest_inc;
											end
										end
									end
								end
								default: begin
								end
							endcase
						end
					end
					ST_PRIME: begin
						if (32'(k_q) == MAX_TAPS - 1) begin
							k_q     <= '0;
							state_q <= ST_SEL;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					ST_SEL: begin
						k_q <= '0;
						if (filt_q == mjfd_pkg::FILT_NONE) begin
							state_q <= ST_OUT;
						end else if (!en_sel) begin
							filt_q <= filt_q + 1'b1;
						end else if (taps_sel == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
					ST_ISSUE: begin
						if (k_q == taps_sel - 1'b1) begin
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					ST_DRAIN: begin
						if (!v_s1 && !v_s2) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						filt_q  <= filt_q + 1'b1;
						state_q <= ST_SEL;
					end
					ST_OUT: begin
						if (!m_valid_q || m_axis_tready) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Item capture and result register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			joint_q    <= joint_w;
			joint_id_q <= in_joint;
			last_q     <= s_axis_tlast;
			pos_q      <= in_pos;
			vel_q      <= in_vel;
		end
		if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
			out_joint_q <= joint_id_q;
			out_pos_q   <= pos_en_q ? res_q[0] : pos_q;
			out_vel_q   <= vel_en_q ? res_q[1] : vel_q;
			out_accel_q <= acc_en_q ? res_q[2] : '0;
			out_last_q  <= last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, out_accel_q, out_vel_q, out_pos_q, out_joint_q};
	assign m_axis_tlast  = out_last_q;

	// A disabled acceleration filter always reports zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !acc_en_q) |-> (out_accel_q == '0))
		else $error("acceleration nonzero while its filter is disabled");

	// Every issued tap passes through v_s1 and v_s2 to the accumulator.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |=> ##1 v_s2)
		else $error("multiply-accumulate pipeline lost a tap");

	// The last sample of the first message completes priming.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_mode == mjfd_pkg::MODE_SAMPLE) && joint_ok && s_axis_tlast &&
		!jcount_chg) |=> primed_q)
		else $error("history not primed after last joint sample");

	// No multiply-accumulate work is in flight while the history is swept.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (acc_q == '0 || $past(state_q) != ST_CLEAR || !v_s2))
		else $error("accumulator active during history clear");

endmodule

[tb/sv/tb_multi_joint_fir_differentiator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_joint_fir_differentiator: directed and random joint
// messages over many register settings, checked against a cycle-free predictor in a class.
// Depends on mjfd_pkg and the block's top level only.
module tb_multi_joint_fir_differentiator;

	localparam int JOINTS_N = 16;
	localparam int TAPS_N = 8;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 60;
	localparam int ITEM_GOAL = 500;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         mode;
		logic [3:0]         joint;
		logic               last;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic [1:0]         sel;
		logic [2:0]         tap;
		logic signed [31:0] coef;
	} joint_item_t;

	typedef struct {
		logic [3:0]         joint;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic               last;
	} joint_result_t;

	class fir_result_board;
		int unsigned        jcount;
		bit                 enable[3];
		int unsigned        taps[3];
		logic signed [31:0] hist[TAPS_N][JOINTS_N];
		logic signed [31:0] coef[3][TAPS_N];
		int                 newest;
		bit                 fresh_cycle;
		bit                 primed;
		int                 errors;
		joint_result_t      pending_results[$];

		function new();
			clear_history();
			foreach (coef[f, k]) coef[f][k] = '0;
			jcount = 1;
			foreach (enable[f]) enable[f] = 0;
			foreach (taps[f]) taps[f] = 0;
			errors = 0;
		endfunction

		function void clear_history();
			foreach (hist[s, j]) hist[s][j] = '0;
			newest = 0;
			fresh_cycle = 1;
			primed = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [4:0] data);
			case (idx)
				mjfd_pkg::REG_JOINT_COUNT: begin
					if (32'(data) != jcount) clear_history();
					jcount = 32'(data);
				end
				mjfd_pkg::REG_POS_EN:   enable[0] = data[0];
				mjfd_pkg::REG_VEL_EN:   enable[1] = data[0];
				mjfd_pkg::REG_ACC_EN:   enable[2] = data[0];
				mjfd_pkg::REG_POS_TAPS: taps[0] = 32'(data[3:0]);
				mjfd_pkg::REG_VEL_TAPS: taps[1] = 32'(data[3:0]);
				mjfd_pkg::REG_ACC_TAPS: taps[2] = 32'(data[3:0]);
				default: ;
			endcase
		endfunction

		// Exact sum of products, one rounding to nearest with ties upward, then saturation.
		function logic signed [31:0] filter_column(int f, int j);
			logic signed [71:0] acc;
			longint             prod;
			int                 n;
			int                 slot;
			acc = '0;
			n = (taps[f] > TAPS_N) ? TAPS_N : taps[f];
			for (int k = 0; k < n; k++) begin
				slot = (newest + TAPS_N - k) % TAPS_N;
				prod = longint'(hist[slot][j]) * longint'(coef[f][k]);
				acc = acc + 72'(prod);
			end
			acc = (acc + 72'sd32768) >>> 16;
			if (acc > 72'sd2147483647) return 32'sh7FFFFFFF;
			if (acc < -72'sd2147483648) return 32'sh80000000;
			return acc[31:0];
		endfunction

		function void note_input(joint_item_t it);
			joint_result_t r;
			int            j;
			j = 32'(it.joint);
			case (it.mode)
				mjfd_pkg::MODE_SYNC: fresh_cycle = 1;
				mjfd_pkg::MODE_COEF: if (it.sel != mjfd_pkg::FILT_NONE) coef[it.sel][it.tap] = it.coef;
				mjfd_pkg::MODE_SAMPLE: if (j < jcount) begin
					if (!primed) begin
						for (int k = 0; k < TAPS_N; k++) hist[k][j] = it.pos;
						fresh_cycle = 0;
						if (it.last) primed = 1;
					end else begin
						if (fresh_cycle) begin
							newest = (newest + 1) % TAPS_N;
							fresh_cycle = 0;
						end
						hist[newest][j] = it.pos;
					end
					r.joint = it.joint;
					r.pos = enable[0] ? filter_column(0, j) : it.pos;
					r.vel = enable[1] ? filter_column(1, j) : it.vel;
					r.acc = enable[2] ? filter_column(2, j) : '0;
					r.last = it.last;
					pending_results.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(joint_result_t got);
			joint_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result for joint %0d with no sample waiting", got.joint));
				return;
			end
			want = pending_results.pop_front();
			if (got.joint !== want.joint)
				report($sformatf("joint got %0d want %0d", got.joint, want.joint));
			if (got.pos !== want.pos)
				report($sformatf("joint %0d position got %h want %h", want.joint, got.pos, want.pos));
			if (got.vel !== want.vel)
				report($sformatf("joint %0d velocity got %h want %h", want.joint, got.vel, want.vel));
			if (got.acc !== want.acc)
				report($sformatf("joint %0d acceleration got %h want %h", want.joint, got.acc,
					want.acc));
			if (got.last !== want.last)
				report($sformatf("joint %0d last flag got %b want %b", want.joint, got.last,
					want.last));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [4:0]   cfg_data;

	fir_result_board board;
	bit quiet;
	int idle_cycles;
	int n_samples, n_syncs, n_coefs, n_ignored, n_results;

	multi_joint_fir_differentiator #(
		.MAX_JOINTS(JOINTS_N),
		.MAX_TAPS  (TAPS_N)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int items_seen();
		return n_samples + n_syncs + n_coefs + n_ignored;
	endfunction

	function automatic logic signed [31:0] rand_value(int unsigned span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sh0;
				default: return -32'sh1;
			endcase
		end
		if (r <= 3) return $urandom;
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic joint_item_t noise_item();
		joint_item_t it;
		it.mode = 2'($urandom_range(0, 3));
		it.joint = 4'($urandom);
		it.last = 1'($urandom);
		it.pos = $urandom;
		it.vel = $urandom;
		it.sel = 2'($urandom);
		it.tap = 3'($urandom);
		it.coef = $urandom;
		return it;
	endfunction

	initial begin
		m_axis_tready = 0;
		forever begin
			int stall;
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready = 0;
			end else begin
				m_axis_tready = 1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : monitor
		joint_item_t   seen;
		joint_result_t got;
		int            queued_prev;
		bit            moved;
		if (arst_n) begin
			moved = 0;
			if (cfg_valid && cfg_ready) begin
				board.set_reg(cfg_index, cfg_data);
				moved = 1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.mode = s_axis_tuser;
				seen.last = s_axis_tlast;
				seen.joint = s_axis_tdata[3:0];
				seen.pos = s_axis_tdata[35:4];
				seen.vel = s_axis_tdata[67:36];
				seen.sel = s_axis_tdata[69:68];
				seen.tap = s_axis_tdata[72:70];
				seen.coef = s_axis_tdata[104:73];
				queued_prev = board.pending_results.size();
				board.note_input(seen);
				if (board.pending_results.size() != queued_prev) n_samples++;
				else if (seen.mode == mjfd_pkg::MODE_SYNC) n_syncs++;
				else if (seen.mode == mjfd_pkg::MODE_COEF) n_coefs++;
				else n_ignored++;
				moved = 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.joint = m_axis_tdata[3:0];
				got.pos = m_axis_tdata[35:4];
				got.vel = m_axis_tdata[67:36];
				got.acc = m_axis_tdata[99:68];
				got.last = m_axis_tlast;
				board.check_result(got);
				n_results++;
				moved = 1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no handshake for %0d cycles", IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send(joint_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {7'd0, it.coef, it.tap, it.sel, it.vel, it.pos, it.joint};
		s_axis_tuser = it.mode;
		s_axis_tlast = it.last;
		s_axis_tvalid = 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic sample(int j, bit last, logic signed [31:0] p, logic signed [31:0] v);
		joint_item_t it;
		it = noise_item();
		it.mode = mjfd_pkg::MODE_SAMPLE;
		it.joint = 4'(j);
		it.last = last;
		it.pos = p;
		it.vel = v;
		send(it);
	endtask

	task automatic tick();
		joint_item_t it;
		it = noise_item();
		it.mode = mjfd_pkg::MODE_SYNC;
		send(it);
	endtask

	task automatic load_coef(logic [1:0] sel, logic [2:0] tap, logic signed [31:0] c);
		joint_item_t it;
		it = noise_item();
		it.mode = mjfd_pkg::MODE_COEF;
		it.sel = sel;
		it.tap = tap;
		it.coef = c;
		send(it);
	endtask

	// Lets every expected result arrive, then gives the block time to finish any silent work.
	task automatic drain();
		s_axis_tvalid = 0;
		while (board.pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [4:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic configure(int jc, bit pe, bit ve, bit ae, int pt, int vt, int at);
		drain();
		write_reg(mjfd_pkg::REG_JOINT_COUNT, 5'(jc));
		write_reg(mjfd_pkg::REG_POS_EN, 5'(pe));
		write_reg(mjfd_pkg::REG_VEL_EN, 5'(ve));
		write_reg(mjfd_pkg::REG_ACC_EN, 5'(ae));
		write_reg(mjfd_pkg::REG_POS_TAPS, 5'(pt));
		write_reg(mjfd_pkg::REG_VEL_TAPS, 5'(vt));
		write_reg(mjfd_pkg::REG_ACC_TAPS, 5'(at));
	endtask

	// A sync tick followed by one sample per joint, sometimes with the tick left out, an extra
	// tick in the middle, or one joint missing.
	task automatic send_message(int joints);
		int flaw;
		int mid;
		flaw = $urandom_range(0, 9);
		mid = $urandom_range(0, joints - 1);
		if (flaw != 0) tick();
		for (int j = 0; j < joints; j++) begin
			if (flaw == 1 && j == mid && j > 0) tick();
			if (!(flaw == 2 && j == mid && joints > 1))
				sample(j, j == joints - 1, rand_value(1 << 20), rand_value(1 << 20));
		end
	endtask

	function automatic int rand_taps();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
	endfunction

	initial begin
		joint_item_t it;
		int          phase;
		int          goal;
		int          jc;
		int          joints;
		int          r;
		logic [1:0]  sel;

		board = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = mjfd_pkg::MODE_SYNC;
		s_axis_tlast = 0;
		cfg_valid = 0;
		cfg_index = mjfd_pkg::REG_JOINT_COUNT;
		cfg_data = '0;
		quiet = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset settings: one joint, all filters passed through.
		sample(0, 1, 32'sh7FFFFFFF, 32'sh80000000);
		it = noise_item();
		it.mode = MODE_UNUSED;
		send(it);
		sample(1, 1, 32'sh00010000, 32'sh00010000);

		configure(4, 1, 1, 1, 8, 3, 15);
		load_coef(mjfd_pkg::FILT_POS, 3'd0, 32'sh7FFFFFFF);
		load_coef(mjfd_pkg::FILT_POS, 3'd7, 32'sh80000000);
		load_coef(mjfd_pkg::FILT_VEL, 3'd0, 32'sh00010000);
		load_coef(mjfd_pkg::FILT_VEL, 3'd1, -32'sh00010000);
		load_coef(mjfd_pkg::FILT_ACC, 3'd0, 32'sh00010000);
		load_coef(mjfd_pkg::FILT_ACC, 3'd1, -32'sh00020000);
		load_coef(mjfd_pkg::FILT_ACC, 3'd2, 32'sh00010000);
		load_coef(mjfd_pkg::FILT_NONE, 3'd5, 32'sh12345678);
		sample(0, 0, 32'sh80000000, 32'sh0);
		sample(1, 0, 32'sh7FFFFFFF, -32'sh1);
		sample(2, 0, 32'sh0, 32'sh7FFFFFFF);
		sample(3, 1, 32'sh00010000, 32'sh80000000);
		tick();
		sample(0, 0, 32'sh00020000, 32'sh0);
		sample(1, 0, -32'sh00008000, 32'sh0);
		tick();
		sample(2, 0, 32'sh00018000, 32'sh0);
		sample(3, 1, 32'sh7FFFFFFF, 32'sh0);

		phase = 0;
		while (items_seen() < ITEM_GOAL) begin
			case (phase)
				0: configure(16, 1, 1, 1, 8, 8, 8);
				1: configure(0, 1'($urandom), 1'($urandom), 1'($urandom), 0, 0, 0);
				2: configure(31, 1, 1, 1, 15, 0, 15);
				3: configure(1, 0, 0, 0, rand_taps(), rand_taps(), rand_taps());
				default: begin
					jc = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) :
						$urandom_range(1, 16);
					configure(jc, 1'($urandom), 1'($urandom), 1'($urandom), rand_taps(),
						rand_taps(), rand_taps());
				end
			endcase
			jc = board.jcount;
			quiet = ($urandom_range(0, 3) == 0);
			goal = items_seen() + ((jc == 0) ? 20 : 60);
			while (items_seen() < goal) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					load_coef(2'($urandom), 3'($urandom), rand_value(1 << 17));
				end else if (r < 12) begin
					sel = 2'($urandom_range(0, 2));
					for (int k = 0; k < TAPS_N; k++) load_coef(sel, 3'(k), rand_value(1 << 17));
				end else if (r < 80) begin
					joints = (jc == 0) ? $urandom_range(1, 3) : ((jc > JOINTS_N) ? JOINTS_N : jc);
					send_message(joints);
				end else if (r < 88) begin
					tick();
				end else begin
					send(noise_item());
				end
			end
			phase++;
		end
		drain();
		if (board.pending_results.size() != 0)
			board.report($sformatf("%0d results never arrived", board.pending_results.size()));

		$display("covered %0d setting phases: %0d samples with results, %0d sync ticks,", phase,
			n_samples, n_syncs);
		$display("%0d coefficient loads, %0d ignored items, %0d results checked, %0d mismatches",
			n_coefs, n_ignored, n_results, board.errors);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
